/* hdl/vnu_pkg.sv */
// shared types and constants of the vector normalize unit
package vnu_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int COMP_W        = 16;
	localparam int SQ_W          = 31;
	localparam int SUMSQ_W       = 32;
	localparam int NCOMP         = 3;

	typedef struct packed {
		logic valid;
		logic zero;
	} ctl_t;

endpackage

/* hdl/vnu_prep.sv */
// front stages: magnitudes, squares, sum of squares and initial residuals
module vnu_prep #(
	parameter int FRAC_BITS = vnu_pkg::FRAC_BITS_DEF,
	localparam int RW = 2 * FRAC_BITS + 40,
	localparam int LW = FRAC_BITS + 36
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	input  logic signed [vnu_pkg::COMP_W-1:0]        comp    [vnu_pkg::NCOMP],
	output vnu_pkg::ctl_t                            ctl_s2,
	output logic        [vnu_pkg::SUMSQ_W-1:0]       sum_s2,
	output logic signed [RW-1:0]                     res_s2  [vnu_pkg::NCOMP],
	output logic signed [LW-1:0]                     lin_s2  [vnu_pkg::NCOMP],
	output logic                                     neg_s2  [vnu_pkg::NCOMP]
);

	logic                       valid_s1;
	logic [vnu_pkg::SQ_W-1:0]   sq_s1  [vnu_pkg::NCOMP];
	logic                       neg_s1 [vnu_pkg::NCOMP];
	logic [vnu_pkg::COMP_W:0]   mag    [vnu_pkg::NCOMP];
	logic [vnu_pkg::SUMSQ_W-1:0] sum;

	always_comb begin
		for (int i = 0; i < vnu_pkg::NCOMP; i++) begin
			if (comp[i][vnu_pkg::COMP_W-1]) begin
				mag[i] = (vnu_pkg::COMP_W+1)'(0) - {comp[i][vnu_pkg::COMP_W-1], comp[i]};
			end else begin
				mag[i] = {1'b0, comp[i]};
			end
		end
		sum = vnu_pkg::SUMSQ_W'(sq_s1[0]) + vnu_pkg::SUMSQ_W'(sq_s1[1])
			+ vnu_pkg::SUMSQ_W'(sq_s1[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ctl_s2   <= '0;
		end else begin
			valid_s1     <= in_valid;
			ctl_s2.valid <= valid_s1;
			ctl_s2.zero  <= (sum == '0);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < vnu_pkg::NCOMP; i++) begin
			sq_s1[i]  <= vnu_pkg::SQ_W'(mag[i] * mag[i]);
			neg_s1[i] <= comp[i][vnu_pkg::COMP_W-1];
			// residual starts at 4 m^2 2^(2F) - s, linear term at -s
			res_s2[i] <= ({{(RW-vnu_pkg::SQ_W){1'b0}}, sq_s1[i]} << (2 * FRAC_BITS + 2))
				- {{(RW-vnu_pkg::SUMSQ_W){1'b0}}, sum};
			lin_s2[i] <= LW'(0) - {{(LW-vnu_pkg::SUMSQ_W){1'b0}}, sum};
			neg_s2[i] <= neg_s1[i];
		end
		sum_s2 <= sum;
	end

endmodule

/* hdl/vnu_cell.sv */
// one result bit of the reciprocal-root scaling for all three components
module vnu_cell #(
	parameter int FRAC_BITS = vnu_pkg::FRAC_BITS_DEF,
	parameter int BIT       = vnu_pkg::FRAC_BITS_DEF,
	localparam int RW = 2 * FRAC_BITS + 40,
	localparam int LW = FRAC_BITS + 36
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  vnu_pkg::ctl_t                       ctl_in,
	input  logic        [vnu_pkg::SUMSQ_W-1:0]  sum_in,
	input  logic signed [RW-1:0]                res_in  [vnu_pkg::NCOMP],
	input  logic signed [LW-1:0]                lin_in  [vnu_pkg::NCOMP],
	input  logic        [FRAC_BITS:0]           q_in    [vnu_pkg::NCOMP],
	input  logic                                neg_in  [vnu_pkg::NCOMP],
	output vnu_pkg::ctl_t                       ctl_q,
	output logic        [vnu_pkg::SUMSQ_W-1:0]  sum_q,
	output logic signed [RW-1:0]                res_q   [vnu_pkg::NCOMP],
	output logic signed [LW-1:0]                lin_q   [vnu_pkg::NCOMP],
	output logic        [FRAC_BITS:0]           q_q     [vnu_pkg::NCOMP],
	output logic                                neg_q   [vnu_pkg::NCOMP]
);

	logic [RW-1:0] s_ext;
	logic [RW-1:0] cand [vnu_pkg::NCOMP];
	logic          take [vnu_pkg::NCOMP];

	always_comb begin
		s_ext = {{(RW-vnu_pkg::SUMSQ_W){1'b0}}, sum_in};
		for (int i = 0; i < vnu_pkg::NCOMP; i++) begin
			// residual after trying d = 2q - 1 + 2^(BIT+1)
			cand[i] = res_in[i] - ({{(RW-LW){lin_in[i][LW-1]}}, lin_in[i]} << (BIT + 2))
				- (s_ext << (2 * BIT + 2));
			// once the top bit is set the value sits at the clamp
			take[i] = !q_in[i][FRAC_BITS] && !cand[i][RW-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		sum_q <= sum_in;
		for (int i = 0; i < vnu_pkg::NCOMP; i++) begin
			neg_q[i] <= neg_in[i];
			if (take[i]) begin
				res_q[i] <= cand[i];
				lin_q[i] <= lin_in[i] + (LW'(sum_in) << (BIT + 1));
				q_q[i]   <= q_in[i] | ((FRAC_BITS + 1)'(1) << BIT);
			end else begin
				res_q[i] <= res_in[i];
				lin_q[i] <= lin_in[i];
				q_q[i]   <= q_in[i];
			end
		end
	end

endmodule

/* hdl/vector3_normalize_unit.sv */
// top level of the three-component vector normalize unit
//
// An item (vec_x, vec_y, vec_z) is taken at a rising edge with start high and
// busy low. busy is always low: a new item may enter every cycle.
// Each result (unit_x, unit_y, unit_z, zero_length) is on the ports for one
// cycle, marked by done; the receiver cannot stall, so results are never held.
// Two front stages form the squares and the sum of squares, then a row of
// FRAC_BITS + 1 cells each settles one bit of every scaled component, then an
// output register applies the sign. Throughput is one item per cycle.
// Each component v becomes v * 2^FRAC_BITS / sqrt(x*x + y*y + z*z), rounded to nearest,
// in signed Q2.14 at the default. A zero vector gives zeros with zero_length.
// Reset empties the pipeline; items in flight are dropped and no done follows.
module vector3_normalize_unit #(
	parameter int FRAC_BITS = vnu_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [vnu_pkg::COMP_W-1:0]  vec_x,
	input  logic signed [vnu_pkg::COMP_W-1:0]  vec_y,
	input  logic signed [vnu_pkg::COMP_W-1:0]  vec_z,
	output logic                               done,
	output logic signed [vnu_pkg::COMP_W-1:0]  unit_x,
	output logic signed [vnu_pkg::COMP_W-1:0]  unit_y,
	output logic signed [vnu_pkg::COMP_W-1:0]  unit_z,
	output logic                               zero_length
);

	localparam int RW = 2 * FRAC_BITS + 40;
	localparam int LW = FRAC_BITS + 36;
	localparam int NC = FRAC_BITS + 1;
	localparam int EW = (FRAC_BITS + 2 > vnu_pkg::COMP_W) ? FRAC_BITS + 2 : vnu_pkg::COMP_W;

	logic signed [vnu_pkg::COMP_W-1:0] comp [vnu_pkg::NCOMP];

	vnu_pkg::ctl_t                       ctl_ch [NC+1];
	logic        [vnu_pkg::SUMSQ_W-1:0]  sum_ch [NC+1];
	logic signed [RW-1:0]                res_ch [NC+1][vnu_pkg::NCOMP];
	logic signed [LW-1:0]                lin_ch [NC+1][vnu_pkg::NCOMP];
	logic        [FRAC_BITS:0]           q_ch   [NC+1][vnu_pkg::NCOMP];
	logic                                neg_ch [NC+1][vnu_pkg::NCOMP];

	logic [EW-1:0] sval [vnu_pkg::NCOMP];

	assign busy = 1'b0;
	assign comp[0] = vec_x;
	assign comp[1] = vec_y;
	assign comp[2] = vec_z;

	vnu_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.comp     (comp),
		.ctl_s2   (ctl_ch[0]),
		.sum_s2   (sum_ch[0]),
		.res_s2   (res_ch[0]),
		.lin_s2   (lin_ch[0]),
		.neg_s2   (neg_ch[0])
	);

	always_comb begin
		for (int i = 0; i < vnu_pkg::NCOMP; i++) begin
			q_ch[0][i] = '0;
		end
	end

	for (genvar k = 0; k < NC; k++) begin : g_cell
		vnu_cell #(.FRAC_BITS(FRAC_BITS), .BIT(FRAC_BITS - k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_in (ctl_ch[k]),
			.sum_in (sum_ch[k]),
			.res_in (res_ch[k]),
			.lin_in (lin_ch[k]),
			.q_in   (q_ch[k]),
			.neg_in (neg_ch[k]),
			.ctl_q  (ctl_ch[k+1]),
			.sum_q  (sum_ch[k+1]),
			.res_q  (res_ch[k+1]),
			.lin_q  (lin_ch[k+1]),
			.q_q    (q_ch[k+1]),
			.neg_q  (neg_ch[k+1])
		);
	end

	always_comb begin
		for (int i = 0; i < vnu_pkg::NCOMP; i++) begin
			if (ctl_ch[NC].zero) begin
				sval[i] = '0;
			end else if (neg_ch[NC][i]) begin
				sval[i] = EW'(0) - EW'(q_ch[NC][i]);
			end else begin
				sval[i] = EW'(q_ch[NC][i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_ch[NC].valid;
		end
	end

	always_ff @(posedge clk) begin
		unit_x      <= sval[0][vnu_pkg::COMP_W-1:0];
		unit_y      <= sval[1][vnu_pkg::COMP_W-1:0];
		unit_z      <= sval[2][vnu_pkg::COMP_W-1:0];
		zero_length <= ctl_ch[NC].zero;
	end

endmodule
